// ===== rtl/serial_frame_receiver_sum_check_macros.svh =====
// Assertion macros for the frame receiver checker.
`ifndef SERIAL_FRAME_RECEIVER_SUM_CHECK_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_SUM_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFRSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define SFRSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

// ===== rtl/sfrsc_pkg.sv =====
// Package: sizes, control types and state codes of the frame receiver.
`default_nettype none
package sfrsc_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int HEADER_RESET  = 8'hAA;
  localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int IDX_W = 5;

  // Shift command handed down the cell chain.
  typedef struct packed {
    logic       shift;
    logic [7:0] din;
  } chain_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PAYLOAD = 4'b0010,
    ST_CHECK   = 4'b0100,
    ST_DRAIN   = 4'b1000
  } rx_state_t;

endpackage
`default_nettype wire

// ===== rtl/sfrsc_cell.sv =====
// One byte cell of the payload chain.
`default_nettype none
module sfrsc_cell (
  input  wire                       clk,
  input  sfrsc_pkg::chain_ctrl_t    ctrl,
  output logic [7:0]                dout
);
  import sfrsc_pkg::*;

  // Take the neighbor's byte on shift, hold otherwise.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      dout <= ctrl.din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfrsc_chain.sv =====
// Row of byte cells that stores the payload and shifts it out oldest first.
`default_nettype none
module sfrsc_chain (
  input  wire                       clk,
  input  sfrsc_pkg::chain_ctrl_t    ctrl,
  output logic [7:0]                dout
);
  import sfrsc_pkg::*;

  logic [7:0]  cell_q    [PAYLOAD_BYTES];
  chain_ctrl_t cell_ctrl [PAYLOAD_BYTES];

  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_ctrl[i] = ctrl;
    end else begin : g_link
      assign cell_ctrl[i] = '{shift: ctrl.shift, din: cell_q[i-1]};
    end
    sfrsc_cell u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl[i]),
      .dout (cell_q[i])
    );
  end

  assign dout = cell_q[PAYLOAD_BYTES-1];

endmodule
`default_nettype wire

// ===== rtl/serial_frame_receiver_sum_check.sv =====
// Top level: serial frame deframer with additive checksum.
//
// Input channel (in_valid/in_ready, rx_byte) takes one received serial word
// per cycle. A word equal to header_byte starts a frame; the next 32 words
// are payload, shifted into a chain of 32 byte cells while an 8-bit sum
// accumulates them modulo 256. The following word is the check byte.
// On a match the chain drains through the output register: 32 result words
// (payload_byte, byte_index, last_of_frame) on out_valid/out_ready, the
// first loaded in the drain state after the check byte, then one per cycle
// while out_ready stays high. On a mismatch the frame is dropped silently.
// Outside a drain one input word is taken every cycle; during the drain
// in_ready is low. The drain ends on the counter's last position, and the
// cell chain moves one byte a cycle unless out_ready stalls it.
// A stall on out_ready holds the output register and the chain in place.
// Reset (rst, synchronous) returns to idle, clears the sum, empties the
// output register and sets header_byte to 0xAA; the chain is not cleared,
// every cell is written before a frame is sent. The user writes header_byte
// via cfg_we/cfg_wdata only while the block is idle; nothing enforces this.
`default_nettype none
module serial_frame_receiver_sum_check (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [7:0]                   cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   rx_byte,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [7:0]                   payload_byte,
  output logic [sfrsc_pkg::IDX_W-1:0]  byte_index,
  output logic                         last_of_frame
);
  import sfrsc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  rx_state_t        state;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       running_sum;
  logic [7:0]       header_byte;
  logic [7:0]       chain_out;
  chain_ctrl_t      chain_ctrl;
  logic             in_take;
  logic             load;

  // Take input in every state but the drain.
  assign in_ready = (state != ST_DRAIN);
  assign in_take  = in_valid && in_ready;

  // Move one stored byte into the output register when it is free.
  assign load = (state == ST_DRAIN) && (!out_valid || out_ready);

  // Shift on a payload word or on a drain step; never both at once.
  assign chain_ctrl.shift = (in_take && (state == ST_PAYLOAD)) || load;
  assign chain_ctrl.din   = rx_byte;

  sfrsc_chain u_chain (
    .clk  (clk),
    .ctrl (chain_ctrl),
    .dout (chain_out)
  );

  // Header register.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'(HEADER_RESET);
    end else if (cfg_we) begin
      header_byte <= cfg_wdata;
    end
  end

  // Frame sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      running_sum <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take && (rx_byte == header_byte)) begin
            state       <= ST_PAYLOAD;
            cnt         <= '0;
            running_sum <= '0;
          end
        end
        ST_PAYLOAD: begin
          if (in_take) begin
            running_sum <= running_sum + rx_byte;
            if (cnt == CNT_LAST) begin
              state <= ST_CHECK;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_CHECK: begin
          // Check byte is never examined as a new header.
          if (in_take) begin
            cnt   <= '0;
            state <= (rx_byte == running_sum) ? ST_DRAIN : ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            if (cnt == CNT_LAST) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // Output register: valid bit under reset, payload loaded on a drain step.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      payload_byte  <= chain_out;
      byte_index    <= IDX_W'(cnt);
      last_of_frame <= (cnt == CNT_LAST);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfrsc_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none
`include "serial_frame_receiver_sum_check_macros.svh"
module sfrsc_checker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_ready,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire  [7:0]                   payload_byte,
  input  wire  [sfrsc_pkg::IDX_W-1:0]  byte_index,
  input  wire                          last_of_frame
);
  import sfrsc_pkg::*;

  // A stalled result holds its payload.
  `SFRSC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(payload_byte) && $stable(byte_index) && $stable(last_of_frame))

  // The final byte carries the last position.
  `SFRSC_ASSERT_NOW(a_last_index, clk, rst, out_valid && last_of_frame,
    byte_index == IDX_W'(PAYLOAD_BYTES - 1))

  // Inside a frame the next byte follows at once with the next position.
  `SFRSC_ASSERT_NEXT(a_index_step, clk, rst, out_valid && out_ready && !last_of_frame,
    out_valid && (byte_index == $past(byte_index) + 1'b1))

  // No input is taken while a frame is still being sent.
  `SFRSC_ASSERT_NOW(a_no_input_mid_frame, clk, rst, out_valid && !last_of_frame,
    !in_ready)

endmodule

bind serial_frame_receiver_sum_check sfrsc_checker u_sfrsc_checker (.*);
`default_nettype wire

// ===== verif/sfrsc_checker.sv =====
// Checker for the frame receiver: predicts payload words from accepted serial words and compares.
module sfrsc_scoreboard (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [7:0]                   cfg_wdata,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire  [7:0]                   rx_byte,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire  [7:0]                   payload_byte,
  input  wire  [sfrsc_pkg::IDX_W-1:0]  byte_index,
  input  wire                          last_of_frame,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output logic                         idle
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfrsc_pkg::*;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             last;
  } payload_word_t;

  payload_word_t frame_words_due[$];

  logic [7:0] start_byte;
  rx_state_t  rx_phase;
  int         bytes_seen;
  logic [7:0] byte_acc;
  logic [7:0] frame_buf [PAYLOAD_BYTES];

  task automatic report_error(input string msg);
    $display("%0t ns: ERROR: %s", $time, msg);
    fail_count++;
  endtask

  // Advance the frame parser by one serial word; queue the payload on a good check.
  task automatic absorb_byte(input logic [7:0] b);
    payload_word_t w;
    case (rx_phase)
      ST_IDLE: begin
        if (b == start_byte) begin
          byte_acc   = '0;
          bytes_seen = 0;
          rx_phase   = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        frame_buf[bytes_seen] = b;
        byte_acc   = byte_acc + b;
        bytes_seen = bytes_seen + 1;
        if (bytes_seen == PAYLOAD_BYTES) rx_phase = ST_CHECK;
      end
      ST_CHECK: begin
        // Check word is never taken as a new header, match or not.
        if (b == byte_acc) begin
          for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            w.data  = frame_buf[k];
            w.index = IDX_W'(k);
            w.last  = (k == PAYLOAD_BYTES - 1);
            frame_words_due.push_back(w);
          end
        end
        rx_phase = ST_IDLE;
      end
      default: rx_phase = ST_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    payload_word_t want;
    if (rst) begin
      start_byte = 8'(HEADER_RESET);
      rx_phase   = ST_IDLE;
      bytes_seen = 0;
      byte_acc   = '0;
      frame_words_due.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_we) start_byte = cfg_wdata;
      if (in_valid && in_ready) absorb_byte(rx_byte);
      if (out_valid && out_ready) begin
        checked++;
        if (frame_words_due.size() == 0) begin
          report_error($sformatf("unexpected payload word %02h index %0d last %0b",
                                 payload_byte, byte_index, last_of_frame));
        end else begin
          want = frame_words_due.pop_front();
          if (payload_byte !== want.data)
            report_error($sformatf("word %0d: payload_byte %02h, expected %02h",
                                   checked, payload_byte, want.data));
          if (byte_index !== want.index)
            report_error($sformatf("word %0d: byte_index %0d, expected %0d",
                                   checked, byte_index, want.index));
          if (last_of_frame !== want.last)
            report_error($sformatf("word %0d: last_of_frame %0b, expected %0b",
                                   checked, last_of_frame, want.last));
        end
      end
    end
    pending = frame_words_due.size();
    idle    = (rx_phase == ST_IDLE);
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives serial words and header settings into the frame receiver, gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBYTES       = sfrsc_pkg::PAYLOAD_BYTES;
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_WAIT  = 4;     // quiet cycles before a header write
  localparam int DRAIN_WAIT   = 12;    // quiet cycles after the last expected word
  localparam int PHASE_WORDS  = 30;    // serial words per random phase

  // Payload fill patterns for a frame.
  typedef enum int {
    FILL_RANDOM,
    FILL_MIXED,
    FILL_ONES,
    FILL_ZEROS,
    FILL_HEADER,
    FILL_SUM_IS_HEADER
  } fill_kind_t;

  // What goes into the check word.
  typedef enum int {
    CHECK_GOOD,
    CHECK_BAD,
    CHECK_HEADER
  } check_kind_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_we    = 1'b0;
  logic [7:0]                   cfg_wdata = 8'h00;
  logic                         in_valid  = 1'b0;
  logic [7:0]                   rx_byte   = 8'h00;
  logic                         out_ready = 1'b0;
  wire                          in_ready;
  wire                          out_valid;
  wire  [7:0]                   payload_byte;
  wire  [sfrsc_pkg::IDX_W-1:0]  byte_index;
  wire                          last_of_frame;

  int         fail_count;
  int         words_pending;
  int         words_checked;
  logic       parser_idle;

  int         send_idle_pct = 9;
  int         recv_idle_pct = 54;
  int         words_sent    = 0;
  int         headers_used  = 1;
  int         quiet_cycles  = 0;
  logic [7:0] cur_header    = 8'(sfrsc_pkg::HEADER_RESET);

  serial_frame_receiver_sum_check DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last_of_frame(last_of_frame)
  );

  sfrsc_scoreboard u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last_of_frame(last_of_frame),
    .fail_count   (fail_count),
    .pending      (words_pending),
    .checked      (words_checked),
    .idle         (parser_idle)
  );

  always #2 clk = ~clk;

  // Receiver side: drop ready at random on each falling edge, per the current idle rate.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any handshake or register write restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d words still expected",
               STALL_LIMIT, words_pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one serial word, with random gaps first; return at the falling edge after
  // it is taken. Valid stays high, so back-to-back words leave no bubble.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Bias toward the extremes and the header value so they show up inside payloads.
  function automatic logic [7:0] pick_mixed_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return cur_header;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send header, payload and check word as one frame.
  task automatic send_frame(input fill_kind_t fill, input check_kind_t check);
    logic [7:0] body [NBYTES];
    logic [7:0] acc;
    logic [7:0] chk;
    acc = '0;
    for (int k = 0; k < NBYTES; k++) begin
      case (fill)
        FILL_ONES:   body[k] = 8'hFF;
        FILL_ZEROS:  body[k] = 8'h00;
        FILL_HEADER: body[k] = cur_header;
        FILL_MIXED:  body[k] = pick_mixed_byte();
        default:     body[k] = 8'($urandom_range(255));
      endcase
      // Steer the sum onto the header value so the check word equals the header.
      if (fill == FILL_SUM_IS_HEADER && k == NBYTES - 1) body[k] = cur_header - acc;
      acc = acc + body[k];
    end
    case (check)
      CHECK_BAD:    chk = acc ^ 8'($urandom_range(255, 1));
      CHECK_HEADER: chk = cur_header;
      default:      chk = acc;
    endcase
    send_word(cur_header);
    for (int k = 0; k < NBYTES; k++) send_word(body[k]);
    send_word(chk);
  endtask

  // Hold valid low and wait until every predicted word has been seen.
  task automatic drain_results(input int extra);
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Bring the parser back to idle, let the block settle, then write a new header.
  task automatic change_header(input logic [7:0] v);
    while (!parser_idle) send_word(cur_header ^ 8'h01);
    drain_results(SETTLE_WAIT);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we     = 1'b0;
    cur_header = v;
    headers_used++;
  endtask

  // Random traffic: mostly clean frames, some bad checks, cut-off frames and noise.
  task automatic random_phase(input int s_pct, input int r_pct, input logic [7:0] hdr);
    int start;
    int pick;
    fill_kind_t fill;
    change_header(hdr);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) != 0) begin
        fill = ($urandom_range(1) != 0) ? FILL_RANDOM : FILL_MIXED;
      end else begin
        fill = fill_kind_t'($urandom_range(FILL_SUM_IS_HEADER));
      end
      if (pick < 62) begin
        send_frame(fill, CHECK_GOOD);
      end else if (pick < 76) begin
        send_frame(fill, ($urandom_range(3) == 0) ? CHECK_HEADER : CHECK_BAD);
      end else if (pick < 86) begin
        // Cut a frame short; whatever follows lands in its payload or check word.
        send_word(cur_header);
        repeat ($urandom_range(NBYTES)) send_word(pick_mixed_byte());
      end else begin
        repeat ($urandom_range(5, 1)) send_word(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: ignored words in idle, extremes, header inside payload, bad checks.
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h55);
    send_frame(FILL_ONES, CHECK_GOOD);
    send_frame(FILL_HEADER, CHECK_GOOD);
    send_frame(FILL_ZEROS, CHECK_BAD);
    // A mismatching check word equal to the header must not open a frame.
    send_frame(FILL_ZEROS, CHECK_HEADER);
    send_frame(FILL_RANDOM, CHECK_GOOD);
    // A matching check word equal to the header must not open a frame either.
    send_frame(FILL_SUM_IS_HEADER, CHECK_GOOD);
    send_frame(FILL_MIXED, CHECK_GOOD);
    change_header(8'h00);
    send_frame(FILL_ZEROS, CHECK_GOOD);
    send_word(8'h01);
    send_frame(FILL_ONES, CHECK_BAD);

    random_phase(9, 54, 8'hFF);
    random_phase(54, 9, 8'($urandom_range(255)));
    random_phase(0, 0, 8'h00);

    drain_results(DRAIN_WAIT);

    $display("Run covered %0d serial words under %0d header settings and three idling modes.",
             words_sent, headers_used);
    $display("%0d payload words checked, %0d errors.", words_checked, fail_count);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
